/* rtl/qlsf_pkg.sv */
// Shared types, constants and helper functions of the parabolic line search fit.
package qlsf_pkg;

  localparam int StepW   = 32;
  localparam int CostW   = 32;
  localparam int EpsW    = 31;
  localparam int MagW    = 62;
  localparam int DivNumW = 103;
  localparam int MulBW   = 33;
  localparam int MulAccW = 95;
  localparam int QDepth  = 2;

  localparam logic [MagW-1:0] Lim61 = 62'h2000_0000_0000_0000;

  localparam logic RegCurvEps = 1'b0;
  localparam logic RegCostEps = 1'b1;

  typedef enum logic [3:0] {
    B_IDLE, B_S0, B_S1, B_A2, B_OFF, B_VTX, B_T1, B_T, B_T2, B_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [StepW-1:0] k0;
    logic signed [StepW-1:0] k1;
    logic signed [StepW-1:0] k2;
    logic signed [CostW-1:0] j0;
    logic signed [CostW:0]   dj01;
    logic signed [CostW:0]   dj12;
    logic                    degenerate;
    logic signed [StepW-1:0] fb_step;
    logic signed [CostW-1:0] fb_cost;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  typedef struct packed {
    logic            start;
    logic [62:0]     num;
    logic [MagW-1:0] den;
    logic            neg;
    logic            long_sh;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [MagW-1:0]  a;
    logic [MulBW-1:0] b;
    logic             neg;
    logic             long_sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
  } unit_rsp_t;

  function automatic logic [62:0] mag64(logic signed [63:0] x);
    logic [63:0] n;
    n = x[63] ? -x : x;
    return n[62:0];
  endfunction

  function automatic logic [MulBW-1:0] mag33(logic signed [MulBW-1:0] x);
    return x[MulBW-1] ? -x : x;
  endfunction

  function automatic logic signed [63:0] signed_mag(logic [MagW-1:0] m, logic neg);
    logic signed [63:0] v;
    v = $signed({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [CostW-1:0] sat32(logic signed [63:0] x);
    logic signed [CostW-1:0] r;
    if (x > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (x < -64'sd2147483648) r = 32'sh8000_0000;
    else r = x[CostW-1:0];
    return r;
  endfunction

endpackage

/* rtl/qlsf_if.sv */
// Request and result channel interfaces of the parabolic line search fit.
interface qlsf_item_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  step_a;
  logic signed [31:0]  step_b;
  logic signed [31:0]  step_c;
  logic signed [31:0]  cost_a;
  logic signed [31:0]  cost_b;
  logic signed [31:0]  cost_c;
  modport source(output valid, step_a, step_b, step_c, cost_a, cost_b, cost_c, input ready);
  modport sink(input valid, step_a, step_b, step_c, cost_a, cost_b, cost_c, output ready);
endinterface

interface qlsf_result_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  best_step;
  logic signed [31:0]  best_cost;
  logic                from_fit;
  logic                degenerate;
  modport source(output valid, best_step, best_cost, from_fit, degenerate, input ready);
  modport sink(input valid, best_step, best_cost, from_fit, degenerate, output ready);
endinterface

/* rtl/qlsf_front.sv */
// Front part: accepts requests, flags equal steps, picks the fallback point and queues.
module qlsf_front import qlsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  qlsf_item_if.sink         item,
  input  logic [EpsW-1:0]   cost_eps,
  input  logic              pop,
  output head_t             head
);

  localparam int QPtrW = $clog2(QDepth);

  entry_t                  mem [QDepth];
  logic [QPtrW-1:0]        wr;
  logic [QPtrW-1:0]        rd;
  logic [QPtrW:0]          count;
  logic                    accept;
  entry_t                  ent;
  logic signed [CostW+1:0] ce, j0, j1, j2;
  logic                    a_wins, c_wins;

  assign item.ready = count < (QPtrW+1)'(QDepth);
  assign accept     = item.valid && item.ready;

  always_comb begin
    ce = $signed({3'b000, cost_eps});
    j0 = 34'(item.cost_a);
    j1 = 34'(item.cost_b);
    j2 = 34'(item.cost_c);
    a_wins = (j0 <= j1 - ce) && (j0 <= j2 - ce);
    c_wins = (j2 <= j0 - ce) && (j2 <= j1 - ce);
    ent.k0   = item.step_a;
    ent.k1   = item.step_b;
    ent.k2   = item.step_c;
    ent.j0   = item.cost_a;
    ent.dj01 = 33'(item.cost_b) - 33'(item.cost_a);
    ent.dj12 = 33'(item.cost_c) - 33'(item.cost_b);
    ent.degenerate = (item.step_a == item.step_b) || (item.step_a == item.step_c) ||
                     (item.step_b == item.step_c);
    priority if (a_wins) begin
      ent.fb_step = item.step_a;
      ent.fb_cost = item.cost_a;
    end else if (c_wins) begin
      ent.fb_step = item.step_c;
      ent.fb_cost = item.cost_c;
    end else begin
      ent.fb_step = item.step_b;
      ent.fb_cost = item.cost_b;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (accept) wr <= wr + 1'b1;
      if (pop) rd <= rd + 1'b1;
      count <= count + (QPtrW+1)'(accept) - (QPtrW+1)'(pop);
    end
  end

  assign head.valid = count != '0;
  assign head.entry = mem[rd];

endmodule

/* rtl/qlsf_div.sv */
// Restoring divider, one quotient bit a cycle, with the quotient saturated to 2^61.
module qlsf_div import qlsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output unit_rsp_t rsp
);

  logic               busy;
  logic [6:0]         cnt;
  logic [DivNumW-1:0] num;
  logic [MagW-1:0]    den, rem, quo;
  logic               sat, neg;
  logic [MagW:0]      rem2, rem_new, q_next;
  logic               ge, sat_new, last;
  logic [MagW-1:0]    mag_f;
  logic               done;
  logic signed [63:0] value;

  assign rsp.done  = done;
  assign rsp.value = value;

  always_comb begin
    rem2    = {rem, num[DivNumW-1]};
    ge      = rem2 >= {1'b0, den};
    rem_new = ge ? rem2 - {1'b0, den} : rem2;
    q_next  = {quo, ge};
    sat_new = sat || (q_next > {1'b0, Lim61});
    mag_f   = sat_new ? Lim61 : q_next[MagW-1:0];
    last    = cnt == 7'(DivNumW - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (last) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.long_sh ? {req.num, 40'b0} : {16'b0, req.num, 24'b0};
      den <= req.den;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
      neg <= req.neg;
    end else if (busy) begin
      num <= {num[DivNumW-2:0], 1'b0};
      rem <= rem_new[MagW-1:0];
      quo <= q_next[MagW-1:0];
      sat <= sat_new;
      if (last) value <= signed_mag(mag_f, neg);
    end
  end

endmodule

/* rtl/qlsf_mul.sv */
// Shift-and-add multiplier, one multiplier bit a cycle, scaled down and saturated to 2^61.
module qlsf_mul import qlsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mul_req_t  req,
  output unit_rsp_t rsp
);

  logic               busy;
  logic [5:0]         cnt;
  logic [MagW-1:0]    a;
  logic [MulBW-1:0]   b;
  logic [MulAccW-1:0] acc, acc_new;
  logic               neg, long_sh, last, sat;
  logic [70:0]        shifted;
  logic [MagW-1:0]    mag_f;
  logic               done;
  logic signed [63:0] value;

  assign rsp.done  = done;
  assign rsp.value = value;

  always_comb begin
    acc_new = {acc[MulAccW-2:0], 1'b0} + (b[MulBW-1] ? {33'b0, a} : '0);
    shifted = long_sh ? {16'b0, acc_new[MulAccW-1:40]} : acc_new[MulAccW-1:24];
    sat     = shifted > {9'b0, Lim61};
    mag_f   = sat ? Lim61 : shifted[MagW-1:0];
    last    = cnt == 6'(MulBW - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (last) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a       <= req.a;
      b       <= req.b;
      acc     <= '0;
      neg     <= req.neg;
      long_sh <= req.long_sh;
    end else if (busy) begin
      acc <= acc_new;
      b   <= {b[MulBW-2:0], 1'b0};
      if (last) value <= signed_mag(mag_f, neg);
    end
  end

endmodule

/* rtl/qlsf_back.sv */
// Back part: sequences the slope, curvature, vertex and cost steps and holds the result.
module qlsf_back import qlsf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  head_t           head,
  output logic            pop,
  input  logic [EpsW-1:0] curvature_eps,
  qlsf_result_if.source   result
);

  back_state_t             state, state_next;
  entry_t                  cur;
  logic                    issued, issued_next;
  logic signed [63:0]      s0, s1, a2, off2, kv, acc, t, res_cost;
  logic signed [StepW-1:0] res_step;
  logic                    res_fit;
  logic                    load_out;
  div_req_t                div_req;
  mul_req_t                mul_req;
  unit_rsp_t               div_rsp, mul_rsp;
  logic signed [StepW:0]   d01, d12, d02, u33, w33, b33;
  logic signed [63:0]      num_x, den_x, mul_a, kv_calc, need, u64, w64;
  logic [62:0]             num_m, den_m, a_m;
  logic                    div_state, mul_state, vertex_ok, curv_ok;

  qlsf_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  qlsf_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));

  always_comb begin
    d01 = 33'(cur.k1) - 33'(cur.k0);
    d12 = 33'(cur.k2) - 33'(cur.k1);
    d02 = 33'(cur.k2) - 33'(cur.k0);
    u64 = kv - 64'(cur.k0);
    w64 = kv - 64'(cur.k1);
    u33 = u64[StepW:0];
    w33 = w64[StepW:0];
    kv_calc   = (64'(cur.k0) + 64'(cur.k1) - off2) >>> 1;
    vertex_ok = (kv_calc >= 64'(cur.k0)) && (kv_calc <= 64'(cur.k2));
    need      = $signed({17'b0, curvature_eps, 16'b0});
    curv_ok   = (div_rsp.value > 64'sd0) && (div_rsp.value >= need);
    div_state = (state == B_S0) || (state == B_S1) || (state == B_A2) || (state == B_OFF);
    mul_state = (state == B_T1) || (state == B_T) || (state == B_T2);
  end

  // Operand selection for the shared divider and multiplier.
  always_comb begin
    num_x = '0;
    den_x = 64'sd1;
    mul_a = '0;
    b33   = '0;
    div_req.long_sh = 1'b0;
    mul_req.long_sh = 1'b0;
    unique case (state)
      B_S0: begin
        num_x = 64'(cur.dj01);
        den_x = 64'(d01);
        div_req.long_sh = 1'b1;
      end
      B_S1: begin
        num_x = 64'(cur.dj12);
        den_x = 64'(d12);
        div_req.long_sh = 1'b1;
      end
      B_A2: begin
        num_x = s1 - s0;
        den_x = 64'(d02);
      end
      B_OFF: begin
        num_x = s0;
        den_x = a2;
      end
      B_T1: begin
        mul_a = s0;
        b33   = u33;
        mul_req.long_sh = 1'b1;
      end
      B_T: begin
        mul_a = a2;
        b33   = u33;
      end
      B_T2: begin
        mul_a = t;
        b33   = w33;
        mul_req.long_sh = 1'b1;
      end
      default: ;
    endcase
    num_m = mag64(num_x);
    den_m = mag64(den_x);
    a_m   = mag64(mul_a);
    div_req.num   = num_m;
    div_req.den   = den_m[MagW-1:0];
    div_req.neg   = num_x[63] ^ den_x[63];
    div_req.start = div_state && !issued;
    mul_req.a     = a_m[MagW-1:0];
    mul_req.b     = mag33(b33);
    mul_req.neg   = mul_a[63] ^ b33[StepW];
    mul_req.start = mul_state && !issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    if (div_req.start || mul_req.start) issued_next = 1'b1;
    else if (div_rsp.done || mul_rsp.done) issued_next = 1'b0;
    else issued_next = issued;
    unique case (state)
      B_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = head.entry.degenerate ? B_DONE : B_S0;
        end
      end
      B_S0: if (div_rsp.done) state_next = B_S1;
      B_S1: if (div_rsp.done) state_next = B_A2;
      B_A2: if (div_rsp.done) state_next = curv_ok ? B_OFF : B_DONE;
      B_OFF: if (div_rsp.done) state_next = B_VTX;
      B_VTX: state_next = vertex_ok ? B_T1 : B_DONE;
      B_T1: if (mul_rsp.done) state_next = B_T;
      B_T: if (mul_rsp.done) state_next = B_T2;
      B_T2: if (mul_rsp.done) state_next = B_DONE;
      B_DONE: begin
        if (!result.valid || result.ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= head.entry;
      res_step <= head.entry.fb_step;
      res_cost <= 64'(head.entry.fb_cost);
      res_fit  <= 1'b0;
    end
    if (div_rsp.done) begin
      unique case (state)
        B_S0:    s0   <= div_rsp.value;
        B_S1:    s1   <= div_rsp.value;
        B_A2:    a2   <= div_rsp.value;
        default: off2 <= div_rsp.value;
      endcase
    end
    if (state == B_VTX) kv <= kv_calc;
    if (mul_rsp.done) begin
      unique case (state)
        B_T1: acc <= 64'(cur.j0) + mul_rsp.value;
        B_T:  t   <= mul_rsp.value;
        default: begin
          res_cost <= acc + mul_rsp.value;
          res_step <= kv[StepW-1:0];
          res_fit  <= 1'b1;
        end
      endcase
    end
    if (load_out) begin
      result.best_step  <= res_step;
      result.best_cost  <= sat32(res_cost);
      result.from_fit   <= res_fit;
      result.degenerate <= cur.degenerate;
    end
  end

  // The result register frees as soon as the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  a_fit_not_degenerate: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.from_fit) |-> !result.degenerate)
    else $error("fitted result reported for equal steps");

  a_div_done_issued: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (issued && div_state))
    else $error("divider finished with no quotient pending");

  a_mul_done_issued: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (issued && mul_state))
    else $error("multiplier finished with no product pending");

  a_idle_takes_head: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE && head.valid) |=> (state != B_IDLE))
    else $error("queued request left waiting while idle");

endmodule

/* rtl/quadratic_line_search_fit.sv */
// Top level of the three-point parabolic line search fit.
// Requests arrive on the item channel (valid/ready): three ascending trial steps
// (Q8.24) and their costs (Q16.16). Each request gives one result on the result
// channel: the vertex step and predicted cost when the fitted parabola is curved
// enough and its vertex lies between the outer steps, otherwise the best trial point.
// The front part classifies a request in the cycle it is accepted and parks it in a
// two-entry queue, so up to two requests wait while the back part works on another.
// A full fit takes four quotients on the shared bit-serial divider and three
// products on the bit-serial multiplier. A request that falls back before the
// vertex needs fewer steps, and a request with equal steps needs none of them.
// The back part works on one request at a time while the queue takes new ones.
// When the receiver stalls, the result stays in its output register, the back
// part finishes the next request and waits, and the queue fills.
// Reset is synchronous; it empties the queue, drops any result and sets both
// thresholds to 1. The thresholds are written over the APB port at 0x0 and 0x4.
module quadratic_line_search_fit import qlsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qlsf_item_if.sink   item,
  qlsf_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [EpsW-1:0] curvature_eps;
  logic [EpsW-1:0] cost_eps;
  logic            pop;
  head_t           head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curvature_eps <= 31'd1;
      cost_eps      <= 31'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegCurvEps: curvature_eps <= pwdata[EpsW-1:0];
        RegCostEps: cost_eps      <= pwdata[EpsW-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == RegCostEps) ? {1'b0, cost_eps} : {1'b0, curvature_eps};

  qlsf_front u_front (
    .clk(clk), .rst(rst), .item(item), .cost_eps(cost_eps), .pop(pop), .head(head)
  );

  qlsf_back u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .curvature_eps(curvature_eps),
    .result(result)
  );

endmodule
